>>> hdl/nnk8_pkg.sv
// shared types, widths and helpers of the k-nearest-neighbour selector
package nnk8_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 16;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 34;
    localparam int RANK_W  = 3;

    // candidate distance and index as produced by the distance pipeline
    typedef struct packed {
        logic [DIST_W-1:0]  dist_sq;
        logic [INDEX_W-1:0] idx;
    } cand_t;

    // candidate leaving the distance pipeline with its run marks
    typedef struct packed {
        cand_t cand;
        logic  first;
        logic  last;
    } item_t;

    // what one cell hands to its neighbour further down the chain
    typedef struct packed {
        logic               prec;
        logic               valid;
        logic [DIST_W-1:0]  dist_sq;
        logic [INDEX_W-1:0] idx;
    } link_t;

    // slot contents after the current insertion, used for the output snapshot
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  dist_sq;
        logic [INDEX_W-1:0] idx;
    } entry_t;

    // magnitude of the difference of two signed coordinates, always fits 16 bits
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] m;
        begin
            d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
            m = d[COORD_W] ? -d : d;
            return m[COORD_W-1:0];
        end
    endfunction

endpackage

>>> hdl/nearest_neighbors_k8_select.sv
// top level of the streaming k-nearest-neighbour selector
// Takes one candidate point per cycle while s_tready is high. Each transaction
// passes a distance pipeline (absolute difference, 16x16 squares, sum) and then
// enters a chain of NEIGHBOR_COUNT cells that insert it into the list kept
// in ascending distance order, lower index first on equal distance. On a
// transaction marked tlast the updated list is copied into an output shift
// register and drained as NEIGHBOR_COUNT results, one per cycle while m_tready
// is high; the input keeps flowing during the drain. If a tlast transaction
// reaches the chain while the previous run is still draining, s_tready drops
// until the drain completes. Empty slots come out with index and distance zero
// and slot_valid low.
module nearest_neighbors_k8_select #(
    parameter int NEIGHBOR_COUNT = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // query_x, query_y, query_z, point_x, point_y, point_z, point_index
    input  logic [111:0]  s_tdata,
    // first_of_query
    input  logic          s_tuser,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // neighbor_index, distance_sq, rank, 3 zero bits
    output logic [55:0]   m_tdata,
    // slot_valid
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int CW = $clog2(NEIGHBOR_COUNT + 1);

    logic                              en;
    logic                              item_valid;
    nnk8_pkg::item_t                   item;
    logic                              ins_en;
    logic                              load;
    logic                              drain;
    nnk8_pkg::link_t                   links [NEIGHBOR_COUNT+1];
    nnk8_pkg::entry_t                  snaps [NEIGHBOR_COUNT];
    nnk8_pkg::entry_t                  shadow_reg [NEIGHBOR_COUNT];
    logic [CW-1:0]                     out_cnt_reg;
    logic [nnk8_pkg::RANK_W-1:0]       rank_reg;

    // stall only when a run end meets an output still draining
    assign en     = !(item_valid && item.last && (out_cnt_reg != '0));
    assign ins_en = en && item_valid;
    assign load   = ins_en && item.last;
    assign drain  = m_tvalid && m_tready;

    assign s_tready = en;

    nnk8_dist u_dist (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_tvalid),
        .query_x        (s_tdata[15:0]),
        .query_y        (s_tdata[31:16]),
        .query_z        (s_tdata[47:32]),
        .point_x        (s_tdata[63:48]),
        .point_y        (s_tdata[79:64]),
        .point_z        (s_tdata[95:80]),
        .point_index    (s_tdata[111:96]),
        .first_of_query (s_tuser),
        .last_of_query  (s_tlast),
        .out_valid      (item_valid),
        .out_item       (item)
    );

    // insertion chain, slot 0 nearest
    assign links[0] = '0;

    for (genvar g = 0; g < NEIGHBOR_COUNT; g++) begin : g_cell
        nnk8_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (ins_en),
            .clr     (item.first),
            .cand    (item.cand),
            .prev    (links[g]),
            .link    (links[g+1]),
            .snap    (snaps[g])
        );
    end

    // output shift register: snapshot on run end, shift one per transaction
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++) begin
                shadow_reg[i] <= snaps[i].valid ? snaps[i] : '0;
            end
        end else if (drain) begin
            for (int i = 0; i < NEIGHBOR_COUNT - 1; i++) begin
                shadow_reg[i] <= shadow_reg[i+1];
            end
        end
    end

    // remaining result count and rank of the head result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
            rank_reg    <= '0;
        end else if (load) begin
            out_cnt_reg <= CW'(NEIGHBOR_COUNT);
            rank_reg    <= '0;
        end else if (drain) begin
            out_cnt_reg <= out_cnt_reg - CW'(1);
            rank_reg    <= rank_reg + nnk8_pkg::RANK_W'(1);
        end
    end

    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tdata  = {3'b000, rank_reg, shadow_reg[0].dist_sq, shadow_reg[0].idx};
    assign m_tuser  = shadow_reg[0].valid;
    assign m_tlast  = (out_cnt_reg == CW'(1));

    // input is only held back while results are pending
    a_stall_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no results pending");

    // a snapshot starts a full run of results
    a_load_full_run: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (out_cnt_reg == CW'(NEIGHBOR_COUNT)) && (rank_reg == '0))
        else $error("snapshot did not start a full run");

    // the last result of a run empties the output
    a_run_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output still valid after last result");

    // filled slots form a prefix of the run
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tuser && !m_tlast) |=> !m_tuser)
        else $error("filled slot after an empty one");

endmodule

>>> hdl/nnk8_dist.sv
// three-stage squared euclidean distance pipeline
module nnk8_dist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [nnk8_pkg::COORD_W-1:0]  query_x,
    input  logic [nnk8_pkg::COORD_W-1:0]  query_y,
    input  logic [nnk8_pkg::COORD_W-1:0]  query_z,
    input  logic [nnk8_pkg::COORD_W-1:0]  point_x,
    input  logic [nnk8_pkg::COORD_W-1:0]  point_y,
    input  logic [nnk8_pkg::COORD_W-1:0]  point_z,
    input  logic [nnk8_pkg::INDEX_W-1:0]  point_index,
    input  logic                          first_of_query,
    input  logic                          last_of_query,
    output logic                          out_valid,
    output nnk8_pkg::item_t               out_item
);

    logic [2:0]                        valid_reg;
    logic [nnk8_pkg::COORD_W-1:0]      absx_reg;
    logic [nnk8_pkg::COORD_W-1:0]      absy_reg;
    logic [nnk8_pkg::COORD_W-1:0]      absz_reg;
    logic [nnk8_pkg::SQ_W-1:0]         sqx_reg;
    logic [nnk8_pkg::SQ_W-1:0]         sqy_reg;
    logic [nnk8_pkg::SQ_W-1:0]         sqz_reg;
    logic [nnk8_pkg::INDEX_W-1:0]      idx1_reg;
    logic [nnk8_pkg::INDEX_W-1:0]      idx2_reg;
    logic [1:0]                        mark1_reg;
    logic [1:0]                        mark2_reg;
    nnk8_pkg::item_t                   item_reg;

    // stage valid bits, the whole pipe moves together on en
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // stage 1: per-axis magnitude of difference
    always_ff @(posedge aclk) begin
        if (en) begin
            absx_reg  <= nnk8_pkg::abs_diff(query_x, point_x);
            absy_reg  <= nnk8_pkg::abs_diff(query_y, point_y);
            absz_reg  <= nnk8_pkg::abs_diff(query_z, point_z);
            idx1_reg  <= point_index;
            mark1_reg <= {first_of_query, last_of_query};
        end
    end

    // stage 2: one 16x16 square per axis
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg   <= absx_reg * absx_reg;
            sqy_reg   <= absy_reg * absy_reg;
            sqz_reg   <= absz_reg * absz_reg;
            idx2_reg  <= idx1_reg;
            mark2_reg <= mark1_reg;
        end
    end

    // stage 3: sum of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg.cand.dist_sq <= nnk8_pkg::DIST_W'(sqx_reg)
                                   + nnk8_pkg::DIST_W'(sqy_reg)
                                   + nnk8_pkg::DIST_W'(sqz_reg);
            item_reg.cand.idx     <= idx2_reg;
            item_reg.first        <= mark2_reg[1];
            item_reg.last         <= mark2_reg[0];
        end
    end

    assign out_valid = valid_reg[2];
    assign out_item  = item_reg;

endmodule

>>> hdl/nnk8_cell.sv
// one slot of the sorted insertion chain
module nnk8_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              clr,
    input  nnk8_pkg::cand_t   cand,
    input  nnk8_pkg::link_t   prev,
    output nnk8_pkg::link_t   link,
    output nnk8_pkg::entry_t  snap
);

    logic                           valid_reg;
    logic [nnk8_pkg::DIST_W-1:0]    dist_reg;
    logic [nnk8_pkg::INDEX_W-1:0]   idx_reg;
    logic                           valid_next;
    logic [nnk8_pkg::DIST_W-1:0]    dist_next;
    logic [nnk8_pkg::INDEX_W-1:0]   idx_next;
    logic                           eff_valid;
    logic                           prec;

    // a first mark empties the slot for this transaction
    assign eff_valid = valid_reg & ~clr;

    // candidate goes before this slot: empty, nearer, or equal and lower index
    assign prec = !eff_valid
                || (cand.dist_sq < dist_reg)
                || ((cand.dist_sq == dist_reg) && (cand.idx < idx_reg));

    // shift down from the upper neighbour, take the candidate, or hold
    always_comb begin
        priority if (prev.prec) begin
            valid_next = prev.valid;
            dist_next  = prev.dist_sq;
            idx_next   = prev.idx;
        end else if (prec) begin
            valid_next = 1'b1;
            dist_next  = cand.dist_sq;
            idx_next   = cand.idx;
        end else begin
            valid_next = eff_valid;
            dist_next  = dist_reg;
            idx_next   = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
            idx_reg  <= idx_next;
        end
    end

    assign link.prec    = prec;
    assign link.valid   = eff_valid;
    assign link.dist_sq = dist_reg;
    assign link.idx     = idx_reg;

    assign snap.valid   = valid_next;
    assign snap.dist_sq = dist_next;
    assign snap.idx     = idx_next;

endmodule
